// ===== sv/dll_pkg.sv =====
package dll_pkg;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_end;
  } dll_in_t;

  typedef struct packed {
    logic        rec_kind;
    logic [7:0]  value_byte;
    logic [4:0]  token_type;
    logic [2:0]  error_code;
    logic [19:0] tok_line;
    logic [15:0] tok_col;
    logic [15:0] value_length;
    logic        last;
  } dll_out_t;

  typedef enum logic [12:0] {
    M_IDLE  = 13'b0000000000001,
    M_MINUS = 13'b0000000000010,
    M_SLASH = 13'b0000000000100,
    M_DOT   = 13'b0000000001000,
    M_IDENT = 13'b0000000010000,
    M_NUMI  = 13'b0000000100000,
    M_NUMF  = 13'b0000001000000,
    M_QUOTE = 13'b0000010000000,
    M_QESC  = 13'b0000100000000,
    M_HTML  = 13'b0001000000000,
    M_LINEC = 13'b0010000000000,
    M_BLOCK = 13'b0100000000000,
    M_BSTAR = 13'b1000000000000
  } dll_mode_e;

  localparam logic [4:0] TOK_EOF    = 5'd0;
  localparam logic [4:0] TOK_LBRACE = 5'd1;
  localparam logic [4:0] TOK_RBRACE = 5'd2;
  localparam logic [4:0] TOK_LBRACK = 5'd3;
  localparam logic [4:0] TOK_RBRACK = 5'd4;
  localparam logic [4:0] TOK_SEMI   = 5'd5;
  localparam logic [4:0] TOK_COMMA  = 5'd6;
  localparam logic [4:0] TOK_EQUAL  = 5'd7;
  localparam logic [4:0] TOK_ARROW  = 5'd8;
  localparam logic [4:0] TOK_QUOTED = 5'd9;
  localparam logic [4:0] TOK_HTML   = 5'd10;
  localparam logic [4:0] TOK_NUMBER = 5'd11;
  localparam logic [4:0] TOK_IDENT  = 5'd12;
  localparam logic [4:0] TOK_KW0    = 5'd13;
  localparam logic [4:0] TOK_ERROR  = 5'd19;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR   = 3'd1;
  localparam logic [2:0] ERR_IDENT_LONG = 3'd2;
  localparam logic [2:0] ERR_STR_LONG   = 3'd3;
  localparam logic [2:0] ERR_STR_OPEN   = 3'd4;
  localparam logic [2:0] ERR_HTML_LONG  = 3'd5;
  localparam logic [2:0] ERR_HTML_OPEN  = 3'd6;

  localparam logic [1:0] CFG_SQUOTE   = 2'd0;
  localparam logic [1:0] CFG_HASH     = 2'd1;
  localparam logic [1:0] CFG_IDENTMAX = 2'd2;
  localparam logic [1:0] CFG_STRMAX   = 2'd3;

  localparam int unsigned NUM_KW = 6;

  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    {"digraph", 8'h00}, {"graph", 24'h0}, "subgraph",
    {"strict", 16'h0}, {"node", 32'h0}, {"edge", 32'h0}
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd7, 4'd5, 4'd8, 4'd6, 4'd4, 4'd4};

  function automatic logic [7:0] kw_char(input int unsigned k, input logic [15:0] pos);
    logic [2:0] idx;
    logic [63:0] word;
    idx  = 3'(3'd7 - pos[2:0]);
    word = KW_TEXT[k];
    if (pos >= 16'(KW_LEN[k])) begin
      return 8'h00;
    end
    return word[{idx, 3'b000} +: 8];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

// ===== sv/dot_language_lexer.sv =====
// channel | valid     | stall      | payload
// input   | in_valid_i  | in_stall_o  | in_data_i  (char_byte, is_end)
// output  | out_valid_o | out_stall_i | out_data_o (one token beat)
// config  | cfg_we_i    | -           | cfg_idx_i, cfg_wdata_i
// one source byte is taken per cycle when not stalled; its zero to three beats
// land in a four-entry output queue in the same edge, leaving one per cycle
// unless out_stall_i is high; the input stalls while the queue holds more
// than one beat and waits for the queue to drain, longer when the output lags
// reset clears the lexer state, counters, queue and config to defaults
module dot_language_lexer import dll_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  dll_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output dll_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  logic        squote_q, hash_q;
  logic [15:0] identmax_q, strmax_q;

  dll_mode_e   mode_q, mode_d;
  logic        qs_q, qs_d;
  logic [19:0] line_q, line_d, tl_q, tl_d;
  logic [15:0] col_q, col_d, tc_q, tc_d, vc_q, vc_d, hd_q, hd_d;
  logic [5:0]  km_q, km_d;

  dll_out_t [2:0] res;
  logic [1:0]     n;
  logic           room, accept;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  function automatic dll_out_t mk(input logic kind, input logic [7:0] vb, input logic [4:0] ty,
                                  input logic [2:0] er, input logic [19:0] tl,
                                  input logic [15:0] tc, input logic [15:0] len);
    dll_out_t r;
    r.rec_kind     = kind;
    r.value_byte   = vb;
    r.token_type   = ty;
    r.error_code   = er;
    r.tok_line     = tl;
    r.tok_col      = tc;
    r.value_length = len;
    r.last         = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic [7:0]  c, lc, q;
    logic        idle;
    logic [15:0] lim;
    logic [16:0] need;
    logic [4:0]  ty;
    logic [7:0]  sa, sb;
    logic        sbyte, stwo;
    logic [2:0]  scode;
    c = in_data_i.char_byte;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    q = qs_q ? "'" : "\"";
    idle = 1'b0;
    lim = (identmax_q == 16'd0) ? 16'd1 : identmax_q;
    sbyte = 1'b0; stwo = 1'b0; sa = 8'h00; sb = 8'h00; scode = ERR_STR_LONG;
    ty = TOK_IDENT;
    need = '0;
    mode_d = mode_q; qs_d = qs_q; line_d = line_q; col_d = col_q;
    tl_d = tl_q; tc_d = tc_q; vc_d = vc_q; hd_d = hd_q; km_d = km_q;
    res = '0;
    n = 2'd0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (km_q[k] && vc_q == 16'(KW_LEN[k])) ty = TOK_KW0 + 5'(k);
    end
    if (in_data_i.is_end) begin
      case (mode_q)
        M_MINUS: begin res[n] = mk(1'b1, "-", TOK_ERROR, ERR_BAD_CHAR, tl_d, tc_d, 16'd0); n++; end
        M_SLASH: begin res[n] = mk(1'b1, "/", TOK_ERROR, ERR_BAD_CHAR, tl_d, tc_d, 16'd0); n++; end
        M_DOT:   begin res[n] = mk(1'b1, ".", TOK_ERROR, ERR_BAD_CHAR, tl_d, tc_d, 16'd0); n++; end
        M_IDENT: begin res[n] = mk(1'b1, 8'h00, ty, ERR_NONE, tl_d, tc_d, vc_d); n++; end
        M_NUMI, M_NUMF: begin
          res[n] = mk(1'b1, 8'h00, TOK_NUMBER, ERR_NONE, tl_d, tc_d, vc_d); n++;
        end
        M_QUOTE, M_QESC: begin
          res[n] = mk(1'b1, 8'h00, TOK_ERROR, ERR_STR_OPEN, tl_d, tc_d, vc_d); n++;
        end
        M_HTML: begin
          res[n] = mk(1'b1, 8'h00, TOK_ERROR, ERR_HTML_OPEN, tl_d, tc_d, vc_d); n++;
        end
        default: ;
      endcase
      mode_d = M_IDLE;
      tl_d = line_q; tc_d = col_q; vc_d = '0;
      res[n] = mk(1'b1, 8'h00, TOK_EOF, ERR_NONE, tl_d, tc_d, 16'd0); n++;
      line_d = 20'd1; col_d = 16'd1;
    end else begin
      if (c == 8'h0a) begin
        if (line_q != 20'hFFFFF) line_d = line_q + 20'd1;
        col_d = 16'd1;
      end else if (col_q != 16'hFFFF) begin
        col_d = col_q + 16'd1;
      end
      case (mode_q)
        M_MINUS: begin
          if (c == ">" || is_digit(c)) begin
            vc_d = vc_d + 16'd1;
            res[n] = mk(1'b0, "-", TOK_EOF, ERR_NONE, tl_d, tc_d, vc_d); n++;
            vc_d = vc_d + 16'd1;
            res[n] = mk(1'b0, c, TOK_EOF, ERR_NONE, tl_d, tc_d, vc_d); n++;
            if (c == ">") begin
              res[n] = mk(1'b1, 8'h00, TOK_ARROW, ERR_NONE, tl_d, tc_d, vc_d); n++;
              mode_d = M_IDLE;
            end else begin
              mode_d = M_NUMI;
            end
          end else begin
            res[n] = mk(1'b1, "-", TOK_ERROR, ERR_BAD_CHAR, tl_d, tc_d, 16'd0); n++;
            idle = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == "/") mode_d = M_LINEC;
          else if (c == "*") mode_d = M_BLOCK;
          else begin
            res[n] = mk(1'b1, "/", TOK_ERROR, ERR_BAD_CHAR, tl_d, tc_d, 16'd0); n++;
            idle = 1'b1;
          end
        end
        M_DOT: begin
          if (is_digit(c)) begin
            vc_d = vc_d + 16'd1;
            res[n] = mk(1'b0, ".", TOK_EOF, ERR_NONE, tl_d, tc_d, vc_d); n++;
            vc_d = vc_d + 16'd1;
            res[n] = mk(1'b0, c, TOK_EOF, ERR_NONE, tl_d, tc_d, vc_d); n++;
            mode_d = M_NUMF;
          end else begin
            res[n] = mk(1'b1, ".", TOK_ERROR, ERR_BAD_CHAR, tl_d, tc_d, 16'd0); n++;
            idle = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            if (vc_q >= lim) begin
              res[n] = mk(1'b1, 8'h00, TOK_ERROR, ERR_IDENT_LONG, tl_d, tc_d, vc_d); n++;
              idle = 1'b1;
            end else begin
              for (int k = 0; k < NUM_KW; k++) begin
                if (lc != kw_char(k, vc_q)) km_d[k] = 1'b0;
              end
              if (vc_d != 16'hFFFF) vc_d = vc_d + 16'd1;
              res[n] = mk(1'b0, c, TOK_EOF, ERR_NONE, tl_d, tc_d, vc_d); n++;
            end
          end else begin
            res[n] = mk(1'b1, 8'h00, ty, ERR_NONE, tl_d, tc_d, vc_d); n++;
            idle = 1'b1;
          end
        end
        M_NUMI, M_NUMF: begin
          if (is_digit(c) || (c == "." && mode_q == M_NUMI)) begin
            if (vc_d != 16'hFFFF) vc_d = vc_d + 16'd1;
            res[n] = mk(1'b0, c, TOK_EOF, ERR_NONE, tl_d, tc_d, vc_d); n++;
            if (c == ".") mode_d = M_NUMF;
          end else begin
            res[n] = mk(1'b1, 8'h00, TOK_NUMBER, ERR_NONE, tl_d, tc_d, vc_d); n++;
            idle = 1'b1;
          end
        end
        M_QUOTE: begin
          if (c == "\\") mode_d = M_QESC;
          else if (c == q) begin
            res[n] = mk(1'b1, 8'h00, TOK_QUOTED, ERR_NONE, tl_d, tc_d, vc_d); n++;
            mode_d = M_IDLE;
          end else begin
            sbyte = 1'b1; sa = c;
          end
        end
        M_QESC: begin
          mode_d = M_QUOTE;
          sbyte = 1'b1;
          if (c == "\"" || c == "'" || c == "\\") sa = c;
          else if (c == "n") sa = 8'h0a;
          else if (c == "t") sa = 8'h09;
          else begin
            sa = "\\"; sb = c; stwo = 1'b1;
          end
        end
        M_HTML: begin
          scode = ERR_HTML_LONG;
          if (c == ">" && hd_q <= 16'd1) begin
            hd_d = '0;
            res[n] = mk(1'b1, 8'h00, TOK_HTML, ERR_NONE, tl_d, tc_d, vc_d); n++;
            mode_d = M_IDLE;
          end else begin
            if (c == "<" && hd_q != 16'hFFFF) hd_d = hd_q + 16'd1;
            else if (c == ">") hd_d = hd_q - 16'd1;
            sbyte = 1'b1; sa = c;
          end
        end
        M_LINEC: if (c == 8'h0a) mode_d = M_IDLE;
        M_BLOCK: if (c == "*") mode_d = M_BSTAR;
        M_BSTAR: begin
          if (c == "/") mode_d = M_IDLE;
          else if (c != "*") mode_d = M_BLOCK;
        end
        default: idle = 1'b1;
      endcase
      if (sbyte) begin
        need = {1'b0, vc_d} + (stwo ? 17'd2 : 17'd1);
        if (need > {1'b0, strmax_q}) begin
          res[n] = mk(1'b1, 8'h00, TOK_ERROR, scode, tl_d, tc_d, vc_d); n++;
          mode_d = M_IDLE;
        end else begin
          if (vc_d != 16'hFFFF) vc_d = vc_d + 16'd1;
          res[n] = mk(1'b0, sa, TOK_EOF, ERR_NONE, tl_d, tc_d, vc_d); n++;
          if (stwo) begin
            if (vc_d != 16'hFFFF) vc_d = vc_d + 16'd1;
            res[n] = mk(1'b0, sb, TOK_EOF, ERR_NONE, tl_d, tc_d, vc_d); n++;
          end
        end
      end
      if (idle) begin
        mode_d = M_IDLE;
        if (!is_space(c)) begin
          tl_d = line_q; tc_d = col_q; vc_d = '0;
          case (c)
            "{", "}", "[", "]", ";", ",", "=": begin
              vc_d = 16'd1;
              res[n] = mk(1'b0, c, TOK_EOF, ERR_NONE, tl_d, tc_d, vc_d); n++;
              case (c)
                "{":     ty = TOK_LBRACE;
                "}":     ty = TOK_RBRACE;
                "[":     ty = TOK_LBRACK;
                "]":     ty = TOK_RBRACK;
                ";":     ty = TOK_SEMI;
                ",":     ty = TOK_COMMA;
                default: ty = TOK_EQUAL;
              endcase
              res[n] = mk(1'b1, 8'h00, ty, ERR_NONE, tl_d, tc_d, vc_d); n++;
            end
            "-": mode_d = M_MINUS;
            "/": mode_d = M_SLASH;
            ".": mode_d = M_DOT;
            "<": begin mode_d = M_HTML; hd_d = 16'd1; end
            default: begin
              if (c == "#" && hash_q) mode_d = M_LINEC;
              else if (c == "\"" || (c == "'" && squote_q)) begin
                mode_d = M_QUOTE;
                qs_d = (c == "'");
              end else if (is_digit(c)) begin
                vc_d = 16'd1;
                res[n] = mk(1'b0, c, TOK_EOF, ERR_NONE, tl_d, tc_d, vc_d); n++;
                mode_d = M_NUMI;
              end else if (is_alpha(c) || c == "_") begin
                for (int k = 0; k < NUM_KW; k++) begin
                  km_d[k] = (lc == kw_char(k, 16'd0));
                end
                vc_d = 16'd1;
                res[n] = mk(1'b0, c, TOK_EOF, ERR_NONE, tl_d, tc_d, vc_d); n++;
                mode_d = M_IDENT;
              end else begin
                res[n] = mk(1'b1, c, TOK_ERROR, ERR_BAD_CHAR, tl_d, tc_d, 16'd0); n++;
              end
            end
          endcase
        end
      end
    end
    if (n != 2'd0) res[2'(n - 2'd1)].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      squote_q   <= 1'b1;
      hash_q     <= 1'b1;
      identmax_q <= 16'd256;
      strmax_q   <= 16'd4096;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SQUOTE:   squote_q   <= cfg_wdata_i[0];
        CFG_HASH:     hash_q     <= cfg_wdata_i[0];
        CFG_IDENTMAX: identmax_q <= cfg_wdata_i;
        CFG_STRMAX:   strmax_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      qs_q   <= 1'b0;
      line_q <= 20'd1;
      col_q  <= 16'd1;
      tl_q   <= 20'd1;
      tc_q   <= 16'd1;
      vc_q   <= '0;
      hd_q   <= '0;
      km_q   <= '1;
    end else if (accept) begin
      mode_q <= mode_d;
      qs_q   <= qs_d;
      line_q <= line_d;
      col_q  <= col_d;
      tl_q   <= tl_d;
      tc_q   <= tc_d;
      vc_q   <= vc_d;
      hd_q   <= hd_d;
      km_q   <= km_d;
    end
  end

  dll_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (accept ? n : 2'd0),
    .push_data_i (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/dll_queue.sv =====
module dll_queue import dll_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_n_i,
  input  dll_out_t [2:0]      push_data_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dll_out_t            out_data_o
);

  dll_out_t   ent_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign pop         = (cnt_q != 3'd0) && !out_stall_i;
  assign out_valid_o = cnt_q != 3'd0;
  assign out_data_o  = ent_q[rd_q];
  assign room_o      = cnt_q <= 3'd1;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_n_i) begin
        ent_q[2'(wr_q + 2'(i))] <= push_data_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_n_i;
      rd_q  <= rd_q + 2'(pop);
      cnt_q <= cnt_q + 3'(push_n_i) - 3'(pop);
    end
  end

endmodule

// ===== sv/dll_checker.sv =====
module dll_checker import dll_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input dll_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.rec_kind |->
      out_data_o.token_type == TOK_EOF && out_data_o.error_code == ERR_NONE)
    else $error("value beat carries token fields");

  a_err_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.rec_kind |->
      (out_data_o.error_code != ERR_NONE) == (out_data_o.token_type == TOK_ERROR))
    else $error("error code and token type disagree");

  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.tok_line != 20'd0 && out_data_o.tok_col != 16'd0)
    else $error("zero token position");

endmodule

bind dot_language_lexer dll_checker u_dll_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== tb/tb.sv =====
module tb;
  import dll_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  dll_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  dll_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [15:0] cfg_wdata = '0;

  dot_language_lexer dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  always #10 clk_i = ~clk_i;

  dll_in_t  src_q[$];
  dll_out_t token_q[$];
  int       fails = 0;
  int       cycles = 0;
  bit       no_idle = 1'b0;
  int       in_gap = 0;
  int       out_gap = 0;

  // lexer image
  logic        sq_en, hash_en;
  logic [15:0] id_max, str_max;
  dll_mode_e   mode;
  logic        q_single;
  logic [19:0] ln, t_ln;
  logic [15:0] col, t_col, v_cnt, h_depth;
  logic [5:0]  kw_hit;
  dll_out_t    beats[3];
  int          nb;
  string       kw_s[6] = '{"digraph", "graph", "subgraph", "strict", "node", "edge"};

  function automatic bit dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alp(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  task automatic emit(logic kind, logic [7:0] vb, logic [4:0] ty, logic [2:0] er,
                      logic [15:0] len);
    if (nb < 3) begin
      beats[nb] = '{rec_kind: kind, value_byte: vb, token_type: ty, error_code: er,
                    tok_line: t_ln, tok_col: t_col, value_length: len, last: 1'b0};
      nb++;
    end
  endtask

  task automatic put_byte(logic [7:0] b);
    if (v_cnt != 16'hFFFF) v_cnt++;
    emit(1'b0, b, TOK_EOF, ERR_NONE, v_cnt);
  endtask

  task automatic put_rec(logic [4:0] ty);
    emit(1'b1, 8'h00, ty, ERR_NONE, v_cnt);
  endtask

  task automatic put_err(logic [2:0] er, logic [7:0] vb, logic [15:0] len);
    emit(1'b1, vb, TOK_ERROR, er, len);
  endtask

  task automatic ident_byte(logic [7:0] c);
    logic [7:0] lc;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    for (int k = 0; k < 6; k++)
      if (v_cnt >= kw_s[k].len() || kw_s[k][v_cnt] != lc) kw_hit[k] = 1'b0;
    put_byte(c);
  endtask

  task automatic close_ident();
    logic [4:0] ty;
    ty = TOK_IDENT;
    for (int k = 0; k < 6; k++)
      if (kw_hit[k] && v_cnt == kw_s[k].len()) ty = TOK_KW0 + 5'(k);
    put_rec(ty);
    mode = M_IDLE;
  endtask

  task automatic start_tok(logic [7:0] c, logic [19:0] pl, logic [15:0] pc);
    mode = M_IDLE;
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
    t_ln = pl;
    t_col = pc;
    v_cnt = 0;
    case (c)
      "{": begin put_byte(c); put_rec(TOK_LBRACE); end
      "}": begin put_byte(c); put_rec(TOK_RBRACE); end
      "[": begin put_byte(c); put_rec(TOK_LBRACK); end
      "]": begin put_byte(c); put_rec(TOK_RBRACK); end
      ";": begin put_byte(c); put_rec(TOK_SEMI); end
      ",": begin put_byte(c); put_rec(TOK_COMMA); end
      "=": begin put_byte(c); put_rec(TOK_EQUAL); end
      "-": mode = M_MINUS;
      "/": mode = M_SLASH;
      ".": mode = M_DOT;
      "<": begin mode = M_HTML; h_depth = 1; end
      default: begin
        if (c == "#" && hash_en) mode = M_LINEC;
        else if (c == "\"" || (c == "'" && sq_en)) begin
          mode = M_QUOTE;
          q_single = (c == "'");
        end else if (dig(c)) begin
          put_byte(c);
          mode = M_NUMI;
        end else if (alp(c) || c == "_") begin
          kw_hit = 6'h3F;
          ident_byte(c);
          mode = M_IDENT;
        end else put_err(ERR_BAD_CHAR, c, 0);
      end
    endcase
  endtask

  task automatic str_bytes(logic [7:0] a, logic [7:0] b, int n, logic [2:0] er);
    if (32'(v_cnt) + n > 32'(str_max)) begin
      put_err(er, 8'h00, v_cnt);
      mode = M_IDLE;
    end else begin
      put_byte(a);
      if (n > 1) put_byte(b);
    end
  endtask

  task automatic predict_tokens(dll_in_t it);
    logic [7:0]  c;
    logic [19:0] pl;
    logic [15:0] pc, lim;
    c = it.char_byte;
    pl = ln;
    pc = col;
    nb = 0;
    if (it.is_end) begin
      case (mode)
        M_MINUS: put_err(ERR_BAD_CHAR, "-", 0);
        M_SLASH: put_err(ERR_BAD_CHAR, "/", 0);
        M_DOT:   put_err(ERR_BAD_CHAR, ".", 0);
        M_IDENT: close_ident();
        M_NUMI, M_NUMF: put_rec(TOK_NUMBER);
        M_QUOTE, M_QESC: put_err(ERR_STR_OPEN, 8'h00, v_cnt);
        M_HTML:  put_err(ERR_HTML_OPEN, 8'h00, v_cnt);
        default: ;
      endcase
      mode = M_IDLE;
      t_ln = ln;
      t_col = col;
      v_cnt = 0;
      put_rec(TOK_EOF);
      ln = 1;
      col = 1;
    end else begin
      if (c == "\n") begin
        if (ln != 20'hFFFFF) ln++;
        col = 1;
      end else if (col != 16'hFFFF) col++;
      case (mode)
        M_MINUS:
          if (c == ">") begin
            put_byte("-"); put_byte(">"); put_rec(TOK_ARROW); mode = M_IDLE;
          end else if (dig(c)) begin
            put_byte("-"); put_byte(c); mode = M_NUMI;
          end else begin
            put_err(ERR_BAD_CHAR, "-", 0); start_tok(c, pl, pc);
          end
        M_SLASH:
          if (c == "/") mode = M_LINEC;
          else if (c == "*") mode = M_BLOCK;
          else begin
            put_err(ERR_BAD_CHAR, "/", 0); start_tok(c, pl, pc);
          end
        M_DOT:
          if (dig(c)) begin
            put_byte("."); put_byte(c); mode = M_NUMF;
          end else begin
            put_err(ERR_BAD_CHAR, ".", 0); start_tok(c, pl, pc);
          end
        M_IDENT: begin
          lim = (id_max == 0) ? 16'd1 : id_max;
          if (alp(c) || dig(c) || c == "_") begin
            if (v_cnt >= lim) begin
              put_err(ERR_IDENT_LONG, 8'h00, v_cnt); start_tok(c, pl, pc);
            end else ident_byte(c);
          end else begin
            close_ident(); start_tok(c, pl, pc);
          end
        end
        M_NUMI:
          if (dig(c)) put_byte(c);
          else if (c == ".") begin
            put_byte(c); mode = M_NUMF;
          end else begin
            put_rec(TOK_NUMBER); start_tok(c, pl, pc);
          end
        M_NUMF:
          if (dig(c)) put_byte(c);
          else begin
            put_rec(TOK_NUMBER); start_tok(c, pl, pc);
          end
        M_QUOTE:
          if (c == "\\") mode = M_QESC;
          else if (c == (q_single ? 8'h27 : 8'h22)) begin
            put_rec(TOK_QUOTED); mode = M_IDLE;
          end else str_bytes(c, 8'h00, 1, ERR_STR_LONG);
        M_QESC: begin
          mode = M_QUOTE;
          if (c == "\"" || c == "'" || c == "\\") str_bytes(c, 8'h00, 1, ERR_STR_LONG);
          else if (c == "n") str_bytes("\n", 8'h00, 1, ERR_STR_LONG);
          else if (c == "t") str_bytes("\t", 8'h00, 1, ERR_STR_LONG);
          else str_bytes("\\", c, 2, ERR_STR_LONG);
        end
        M_HTML:
          if (c == "<") begin
            if (h_depth != 16'hFFFF) h_depth++;
            str_bytes(c, 8'h00, 1, ERR_HTML_LONG);
          end else if (c == ">") begin
            if (h_depth <= 1) begin
              h_depth = 0; put_rec(TOK_HTML); mode = M_IDLE;
            end else begin
              h_depth--; str_bytes(c, 8'h00, 1, ERR_HTML_LONG);
            end
          end else str_bytes(c, 8'h00, 1, ERR_HTML_LONG);
        M_LINEC: if (c == "\n") mode = M_IDLE;
        M_BLOCK: if (c == "*") mode = M_BSTAR;
        M_BSTAR:
          if (c == "/") mode = M_IDLE;
          else if (c != "*") mode = M_BLOCK;
        default: start_tok(c, pl, pc);
      endcase
    end
    if (nb > 0) beats[nb-1].last = 1'b1;
    for (int i = 0; i < nb; i++) token_q.push_back(beats[i]);
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        predict_tokens(in_data);
        void'(src_q.pop_front());
      end
      if (in_valid && in_stall) begin
      end else if (in_gap > 0 && !no_idle) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (src_q.size() > 0 && !no_idle && $urandom_range(0, 19) == 0) begin
        in_gap = $urandom_range(0, 13);
        in_valid <= 1'b0;
      end else if (src_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= src_q[0];
      end else in_valid <= 1'b0;
    end
  end

  task automatic chk(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      $error("%s expected %0d actual %0d", name, e, a);
      fails++;
    end
  endtask

  // output monitor
  always @(posedge clk_i) begin
    dll_out_t e;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (token_q.size() == 0) begin
          $error("unexpected beat %h", out_data);
          fails++;
        end else begin
          e = token_q.pop_front();
          chk("rec_kind", e.rec_kind, out_data.rec_kind);
          chk("value_byte", e.value_byte, out_data.value_byte);
          chk("token_type", e.token_type, out_data.token_type);
          chk("error_code", e.error_code, out_data.error_code);
          chk("tok_line", e.tok_line, out_data.tok_line);
          chk("tok_col", e.tok_col, out_data.tok_col);
          chk("value_length", e.value_length, out_data.value_length);
          chk("last", e.last, out_data.last);
        end
      end
      if (out_gap > 0 && !no_idle) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 15) == 0) begin
        out_gap = $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("dot_language_lexer: mismatch");
      $finish;
    end
  end

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back('{char_byte: s[i], is_end: 1'b0});
  endtask

  task automatic push_end();
    src_q.push_back('{char_byte: 8'($urandom_range(0, 255)), is_end: 1'b1});
  endtask

  task automatic drain();
    wait (src_q.size() == 0 && !in_valid && token_q.size() == 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SQUOTE:   sq_en = val[0];
      CFG_HASH:     hash_en = val[0];
      CFG_IDENTMAX: id_max = val;
      default:      str_max = val;
    endcase
  endtask

  task automatic rand_frag();
    string s;
    int n;
    s = "";
    case ($urandom_range(0, 13))
      0: begin
        s = kw_s[$urandom_range(0, 5)];
        for (int i = 0; i < s.len(); i++)
          if ($urandom_range(0, 1)) s[i] = s[i] - 8'd32;
        if ($urandom_range(0, 2) == 0) s = {s, "x"};
      end
      1: begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(0, 2) == 0 ?
                                         "_" : "a" + $urandom_range(0, 25)))};
      end
      2: s = $sformatf("%0d", $urandom_range(0, 9999));
      3: s = $sformatf("-%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 99));
      4: s = "->";
      5: s = $urandom_range(0, 1) ? "\"ab\\\"c\\n\\t\\\\\\q\"" : "'x\\'y'";
      6: s = $urandom_range(0, 1) ? "<a<b>c>" : "<<>>";
      7: s = $urandom_range(0, 1) ? "// note\n" : "/* ** x */";
      8: s = "# h\n";
      9: s = string'(8'("{}[];,=" >> (8 * $urandom_range(0, 6))));
      10: s = $urandom_range(0, 1) ? " " : "\n\t";
      11: s = string'(8'($urandom_range(1, 255)));
      12: s = $urandom_range(0, 1) ? "-x" : ($urandom_range(0, 1) ? "/x" : ".5 .y");
      default: begin
        push_end();
        return;
      end
    endcase
    if ($urandom_range(0, 3) == 0) src_q.push_back('{char_byte: 8'h00, is_end: 1'b0});
    push_str(s);
    push_str(" ");
  endtask

  task automatic rand_part(int items);
    int goal;
    goal = src_q.size() + items;
    while (src_q.size() < goal) rand_frag();
    push_end();
    drain();
  endtask

  initial begin
    sq_en = 1; hash_en = 1; id_max = 256; str_max = 4096;
    mode = M_IDLE; q_single = 0; ln = 1; col = 1; t_ln = 1; t_col = 1;
    v_cnt = 0; h_depth = 0; kw_hit = 6'h3F;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    push_str("digraph G{a->b;-3 .5 1.2'x\\t'\"q\\\"\\z\"<a<b>c>//c\n/***/#h\n");
    push_str("[=,]} @ -x /x .x STRICT Node EDGE subgraph graph\n");
    push_end();
    push_str("\"ab"); push_end();
    push_str("<ab");  push_end();
    push_str("-");    push_end();
    push_str("/");    push_end();
    push_str(".");    push_end();
    push_str("ab");   push_end();
    push_str("12");   push_end();
    src_q.push_back('{char_byte: 8'hFF, is_end: 1'b0});
    push_end();
    drain();
    rand_part(15);

    cfg_write(CFG_SQUOTE, 16'h0);
    cfg_write(CFG_HASH, 16'h0);
    cfg_write(CFG_IDENTMAX, 16'd1);
    cfg_write(CFG_STRMAX, 16'd1);
    push_str("'a' #x ab \"xy\" \"\\z\" <ab> <a>");
    push_end();
    drain();
    rand_part(10);

    cfg_write(CFG_SQUOTE, 16'h1);
    cfg_write(CFG_HASH, 16'h1);
    cfg_write(CFG_IDENTMAX, 16'd3);
    cfg_write(CFG_STRMAX, 16'd4);
    rand_part(15);

    cfg_write(CFG_IDENTMAX, 16'hFFFF);
    cfg_write(CFG_STRMAX, 16'hFFFF);
    push_str("xxxxxxxxxxxx 1 ");
    push_end();
    drain();

    cfg_write(CFG_IDENTMAX, 16'd256);
    cfg_write(CFG_STRMAX, 16'd4096);
    no_idle = 1'b1;
    rand_part(15);

    repeat (20) @(posedge clk_i);
    if (fails == 0 && token_q.size() == 0) begin
      $display("dot_language_lexer: match");
    end else begin
      $display("dot_language_lexer: mismatch");
    end
    $finish;
  end

endmodule
